// ===== hdl/eprd_pkg.sv =====
// Shared widths, types and register codes for the exclusive prefix rank dot unit.
// Used by eprd_lane, eprd_merge and exclusive_prefix_rank_dot_unit.
package eprd_pkg;

   // Column count fixed by the ports, and the number of columns taking part
   localparam int COLS = 4;
   localparam int RANK = 4;

   // Field and datapath widths
   localparam int VAL_W    = 16;          // Q1.15 factors and the sample
   localparam int WEIGHT_W = 32;          // unsigned Q16.16 weight
   localparam int SUM_W    = 64;          // column sum and row result
   localparam int HALF_W   = 32;          // column sum split point
   localparam int HI_W     = VAL_W + HALF_W;          // v * upper sum half
   localparam int LO_W     = VAL_W + HALF_W + 1;      // v * lower sum half
   localparam int UX_W     = 2 * VAL_W;               // u * x
   localparam int PROD_W   = UX_W + WEIGHT_W + 1;     // u * x * d
   localparam int FRAC_D   = 16;                      // weight fraction bits
   localparam int TERM_W   = 48;                      // term after fraction drop
   localparam int HI_SUM_W = HI_W + 2;                // sum of up to four lanes
   localparam int LO_SUM_W = LO_W + 2;
   localparam int TOT_W    = HI_SUM_W + HALF_W + 1;   // exact dot product
   localparam int FRAC_V   = 15;                      // v fraction bits
   localparam int SHR_W    = TOT_W - FRAC_V;          // dot product, Q.15 fraction dropped

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_3 = 2'd3;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic        [WEIGHT_W-1:0] weight_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [HI_W-1:0] hi_type;
   typedef logic signed [LO_W-1:0] lo_type;

   // Stage strobes from the sequencer to the lanes and the merge stage
   typedef struct packed {
      logic mul;    // form lane products from the held row
      logic acc;    // weight products, merge dot partials
      logic upd;    // commit column sums and the result
      logic last;   // clear column sums after this row
   } stage_ctrl_type;

endpackage

// ===== hdl/eprd_lane.sv =====
// One column lane: holds the column sum, forms the dot partials against it and
// applies the weighted row term with saturation. Depends on eprd_pkg.
module eprd_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  eprd_pkg::stage_ctrl_type ctrl,
   input  eprd_pkg::val_type       left,
   input  eprd_pkg::val_type       right,
   input  eprd_pkg::val_type       sample,
   input  eprd_pkg::weight_type    weight,
   output eprd_pkg::hi_type        vs_hi,
   output eprd_pkg::lo_type        vs_lo,
   output logic                    sat_hit
);

   eprd_pkg::sum_type                        sum_ff;
   eprd_pkg::sum_type                        sum_in;
   eprd_pkg::hi_type                         vs_hi_ff;
   eprd_pkg::lo_type                         vs_lo_ff;
   logic signed [eprd_pkg::UX_W-1:0]         ux_ff;
   logic signed [eprd_pkg::PROD_W-1:0]       prod;
   logic signed [eprd_pkg::TERM_W-1:0]       term_ff;
   logic signed [eprd_pkg::SUM_W:0]          sum_wide;
   logic                                     ovf;

   // Split the sum: signed upper half, unsigned lower half
   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         vs_hi_ff <= right * $signed(sum_ff[eprd_pkg::SUM_W-1:eprd_pkg::HALF_W]);
         vs_lo_ff <= right * $signed({1'b0, sum_ff[eprd_pkg::HALF_W-1:0]});
         ux_ff    <= left * sample;
      end
   end

   // Weight the row entry; upper bits give the floor of the fraction drop
   assign prod = ux_ff * $signed({1'b0, weight});

   always_ff @(posedge clock) begin
      if (ctrl.acc) begin
         term_ff <= prod[eprd_pkg::FRAC_D + eprd_pkg::TERM_W - 1:eprd_pkg::FRAC_D];
      end
   end

   // Saturating column update, or clear after a last row
   assign sum_wide = {sum_ff[eprd_pkg::SUM_W-1], sum_ff}
                   + {{(eprd_pkg::SUM_W + 1 - eprd_pkg::TERM_W){term_ff[eprd_pkg::TERM_W-1]}},
                      term_ff};
   assign ovf      = sum_wide[eprd_pkg::SUM_W] != sum_wide[eprd_pkg::SUM_W-1];

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.upd) begin
         if (ctrl.last) begin
            sum_in = '0;
         end else if (ovf) begin
            sum_in = sum_wide[eprd_pkg::SUM_W] ? {1'b1, {(eprd_pkg::SUM_W-1){1'b0}}}
                                               : {1'b0, {(eprd_pkg::SUM_W-1){1'b1}}};
         end else begin
            sum_in = sum_wide[eprd_pkg::SUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign vs_hi   = vs_hi_ff;
   assign vs_lo   = vs_lo_ff;
   assign sat_hit = ovf;

   // A last row leaves the column empty
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.upd && ctrl.last |=> sum_ff == '0)
      else $error("column sum not cleared after last row");

endmodule

// ===== hdl/eprd_merge.sv =====
// Merge stage: adds the lane dot partials, recombines the halves, drops the
// v fraction and saturates the row result. Depends on eprd_pkg.
module eprd_merge (
   input  logic                                  clock,
   input  eprd_pkg::stage_ctrl_type              ctrl,
   input  eprd_pkg::hi_type [eprd_pkg::RANK-1:0] vs_hi,
   input  eprd_pkg::lo_type [eprd_pkg::RANK-1:0] vs_lo,
   output eprd_pkg::sum_type                     result,
   output logic                                  result_sat
);

   logic signed [eprd_pkg::HI_SUM_W-1:0] hi_acc;
   logic signed [eprd_pkg::LO_SUM_W-1:0] lo_acc;
   logic signed [eprd_pkg::HI_SUM_W-1:0] hi_sum_ff;
   logic signed [eprd_pkg::LO_SUM_W-1:0] lo_sum_ff;
   logic signed [eprd_pkg::TOT_W-1:0]    total;
   logic signed [eprd_pkg::SHR_W-1:0]    shifted;
   logic                                 fits;

   // Sum the lane partials per half
   always_comb begin
      hi_acc = '0;
      lo_acc = '0;
      for (int j = 0; j < eprd_pkg::RANK; j++) begin
         hi_acc = hi_acc + eprd_pkg::HI_SUM_W'($signed(vs_hi[j]));
         lo_acc = lo_acc + eprd_pkg::LO_SUM_W'($signed(vs_lo[j]));
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.acc) begin
         hi_sum_ff <= hi_acc;
         lo_sum_ff <= lo_acc;
      end
   end

   // Recombine, floor by the v fraction, clamp to 64 bits
   assign total   = (eprd_pkg::TOT_W'(hi_sum_ff) <<< eprd_pkg::HALF_W)
                  + eprd_pkg::TOT_W'(lo_sum_ff);
   assign shifted = total[eprd_pkg::TOT_W-1:eprd_pkg::FRAC_V];
   assign fits    = (&shifted[eprd_pkg::SHR_W-1:eprd_pkg::SUM_W-1])
                  | ~(|shifted[eprd_pkg::SHR_W-1:eprd_pkg::SUM_W-1]);

   always_comb begin
      if (fits) begin
         result = shifted[eprd_pkg::SUM_W-1:0];
      end else if (shifted[eprd_pkg::SHR_W-1]) begin
         result = {1'b1, {(eprd_pkg::SUM_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(eprd_pkg::SUM_W-1){1'b1}}};
      end
   end

   assign result_sat = ~fits;

endmodule

// ===== hdl/exclusive_prefix_rank_dot_unit.sv =====
// Top level of the exclusive prefix rank dot unit: row sequencer, weight
// registers, column lanes, merge stage and result register. Depends on eprd_pkg.
//
// Usage:
//   Request channel (req_*): one matrix row per beat, valid/stall handshake.
//   Response channel (rsp_*): one beat per row with the dot product of the
//   right row against the column sums of the earlier rows since the last row
//   with req_last_row set, plus a flag set when any column sum or the result clamped.
//   CSR port (csr_*): write weight_0..weight_3 while the unit is idle.
//   Each row walks a lane through multiply, weight/merge and update, and its
//   response is registered in the update step. A new row is not taken until
//   the previous one reaches the update step, as the next row's products need
//   the column sums that the update writes back.
//   The next row is taken in the update cycle, as long as the response
//   register is empty or is being drained in that cycle.
//   When the receiver stalls, the response holds in its register and the
//   finished row waits in the update step; further rows are stalled.
//   Reset clears the column sums, the weights, the sequencer and rsp_valid.
module exclusive_prefix_rank_dot_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [eprd_pkg::VAL_W-1:0]     req_left_0,
   input  logic signed [eprd_pkg::VAL_W-1:0]     req_left_1,
   input  logic signed [eprd_pkg::VAL_W-1:0]     req_left_2,
   input  logic signed [eprd_pkg::VAL_W-1:0]     req_left_3,
   input  logic signed [eprd_pkg::VAL_W-1:0]     req_right_0,
   input  logic signed [eprd_pkg::VAL_W-1:0]     req_right_1,
   input  logic signed [eprd_pkg::VAL_W-1:0]     req_right_2,
   input  logic signed [eprd_pkg::VAL_W-1:0]     req_right_3,
   input  logic signed [eprd_pkg::VAL_W-1:0]     req_sample_value,
   input  logic                                  req_last_row,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [eprd_pkg::SUM_W-1:0]     rsp_row_result,
   output logic                                  rsp_saturated,
   input  logic                                  csr_write_en,
   input  logic [eprd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [eprd_pkg::WEIGHT_W-1:0]         csr_write_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_ACC  = 4'b0100,
      ST_UPD  = 4'b1000
   } state_type;

   state_type                               state_ff, state_in;
   eprd_pkg::weight_type                    weight_ff [eprd_pkg::COLS];
   eprd_pkg::val_type                       left_ff   [eprd_pkg::COLS];
   eprd_pkg::val_type                       right_ff  [eprd_pkg::COLS];
   eprd_pkg::val_type                       sample_ff;
   logic                                    last_ff;
   logic                                    rsp_valid_ff;
   eprd_pkg::sum_type                       rsp_result_ff;
   logic                                    rsp_sat_ff;
   logic                                    out_free;
   logic                                    upd_go;
   logic                                    req_accept;
   eprd_pkg::stage_ctrl_type                ctrl;
   eprd_pkg::hi_type [eprd_pkg::RANK-1:0]   vs_hi;
   eprd_pkg::lo_type [eprd_pkg::RANK-1:0]   vs_lo;
   logic [eprd_pkg::RANK-1:0]               lane_sat;
   eprd_pkg::sum_type                       merge_result;
   logic                                    merge_sat;

   // Handshake: take a row when idle or when the current row retires
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign upd_go     = (state_ff == ST_UPD) && out_free;
   assign req_stall  = ~((state_ff == ST_IDLE) || upd_go);
   assign req_accept = req_valid & ~req_stall;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: state_in = req_accept ? ST_MUL : ST_IDLE;
         ST_MUL:  state_in = ST_ACC;
         ST_ACC:  state_in = ST_UPD;
         ST_UPD: begin
            if (upd_go) begin
               state_in = req_accept ? ST_MUL : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign ctrl.mul  = state_ff == ST_MUL;
   assign ctrl.acc  = state_ff == ST_ACC;
   assign ctrl.upd  = upd_go;
   assign ctrl.last = last_ff;

   // Weight registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < eprd_pkg::COLS; j++) begin
            weight_ff[j] <= '0;
         end
      end else if (csr_write_en) begin
         unique case (csr_index)
            eprd_pkg::CSR_WEIGHT_0: weight_ff[0] <= csr_write_data;
            eprd_pkg::CSR_WEIGHT_1: weight_ff[1] <= csr_write_data;
            eprd_pkg::CSR_WEIGHT_2: weight_ff[2] <= csr_write_data;
            eprd_pkg::CSR_WEIGHT_3: weight_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Hold the accepted row
   always_ff @(posedge clock) begin
      if (req_accept) begin
         left_ff[0]  <= req_left_0;
         left_ff[1]  <= req_left_1;
         left_ff[2]  <= req_left_2;
         left_ff[3]  <= req_left_3;
         right_ff[0] <= req_right_0;
         right_ff[1] <= req_right_1;
         right_ff[2] <= req_right_2;
         right_ff[3] <= req_right_3;
         sample_ff   <= req_sample_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
      end else if (req_accept) begin
         last_ff <= req_last_row;
      end
   end

   // Column lanes
   for (genvar j = 0; j < eprd_pkg::RANK; j++) begin : g_lane
      eprd_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .left    (left_ff[j]),
         .right   (right_ff[j]),
         .sample  (sample_ff),
         .weight  (weight_ff[j]),
         .vs_hi   (vs_hi[j]),
         .vs_lo   (vs_lo[j]),
         .sat_hit (lane_sat[j])
      );
   end

   eprd_merge u_merge (
      .clock      (clock),
      .ctrl       (ctrl),
      .vs_hi      (vs_hi),
      .vs_lo      (vs_lo),
      .result     (merge_result),
      .result_sat (merge_sat)
   );

   // Response register: load on retire, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (upd_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_go) begin
         rsp_result_ff <= merge_result;
         rsp_sat_ff    <= merge_sat | (|lane_sat);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_result = rsp_result_ff;
   assign rsp_saturated  = rsp_sat_ff;

   a_accept_to_mul: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_MUL)
      else $error("accepted row did not enter the multiply step");

   a_mul_to_acc: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |=> state_ff == ST_ACC)
      else $error("multiply step not followed by merge step");

   a_retire_valid: assert property (@(posedge clock) disable iff (reset)
      upd_go |=> rsp_valid_ff)
      else $error("retired row produced no response beat");

endmodule

// ===== verif/rank_dot_checker.sv =====
// Checker for the exclusive prefix rank dot unit: tracks weight writes, predicts each
// row's response from the column sums of the earlier rows and compares accepted response beats.
// Depends on eprd_pkg for field widths and types.
module rank_dot_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  eprd_pkg::val_type              req_left_0,
   input  eprd_pkg::val_type              req_left_1,
   input  eprd_pkg::val_type              req_left_2,
   input  eprd_pkg::val_type              req_left_3,
   input  eprd_pkg::val_type              req_right_0,
   input  eprd_pkg::val_type              req_right_1,
   input  eprd_pkg::val_type              req_right_2,
   input  eprd_pkg::val_type              req_right_3,
   input  eprd_pkg::val_type              req_sample_value,
   input  logic                           req_last_row,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  eprd_pkg::sum_type              rsp_row_result,
   input  logic                           rsp_saturated,
   input  logic                           csr_write_en,
   input  logic [eprd_pkg::CSR_IDX_W-1:0] csr_index,
   input  eprd_pkg::weight_type           csr_write_data,
   input  logic                           run_done,
   output int                             expected_count,
   output int                             fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      eprd_pkg::sum_type row_result;
      logic              saturated;
   } dot_outcome_type;

   localparam eprd_pkg::sum_type    SUM_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam eprd_pkg::sum_type    SUM_MIN  = -SUM_MAX - 1;
   localparam logic signed [64:0]   WIDE_MAX = SUM_MAX;
   localparam logic signed [64:0]   WIDE_MIN = SUM_MIN;
   localparam logic signed [81:0]   DOT_MAX  = SUM_MAX;
   localparam logic signed [81:0]   DOT_MIN  = SUM_MIN;

   eprd_pkg::sum_type     col_sum [eprd_pkg::COLS];
   eprd_pkg::weight_type  col_weight [eprd_pkg::COLS];
   dot_outcome_type       expected_dots [$];
   int                    mismatches = 0;
   logic                  drain_checked = 1'b0;
   eprd_pkg::val_type     beat_left [eprd_pkg::COLS];
   eprd_pkg::val_type     beat_right [eprd_pkg::COLS];
   dot_outcome_type       want;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // Exclusive dot product from the sums before this row, then fold the row in
   function automatic dot_outcome_type predict_dot(
         input eprd_pkg::val_type u [eprd_pkg::COLS],
         input eprd_pkg::val_type v [eprd_pkg::COLS],
         input eprd_pkg::val_type x,
         input logic last);
      logic signed [81:0] dot;
      logic signed [81:0] v_wide;
      logic signed [81:0] s_wide;
      logic signed [81:0] scaled;
      logic signed [64:0] wide_sum;
      longint             ux;
      longint             prod;
      longint             term;
      dot_outcome_type    o;
      int                 j;
      dot = '0;
      o.saturated = 1'b0;
      for (j = 0; j < eprd_pkg::RANK; j++) begin
         v_wide = v[j];
         s_wide = col_sum[j];
         dot = dot + v_wide * s_wide;
      end
      // drop the v fraction toward minus infinity, then clamp to 64 bits
      scaled = dot >>> eprd_pkg::FRAC_V;
      if (scaled > DOT_MAX) begin
         o.saturated  = 1'b1;
         o.row_result = SUM_MAX;
      end else if (scaled < DOT_MIN) begin
         o.saturated  = 1'b1;
         o.row_result = SUM_MIN;
      end else begin
         o.row_result = scaled[63:0];
      end
      // weighted term keeps the u fraction, drops the weight fraction
      for (j = 0; j < eprd_pkg::RANK; j++) begin
         ux       = longint'(u[j]) * longint'(x);
         prod     = ux * longint'({32'd0, col_weight[j]});
         term     = prod >>> eprd_pkg::FRAC_D;
         wide_sum = {col_sum[j][63], col_sum[j]} + {term[63], term};
         if (wide_sum > WIDE_MAX) begin
            o.saturated = 1'b1;
            col_sum[j]  = SUM_MAX;
         end else if (wide_sum < WIDE_MIN) begin
            o.saturated = 1'b1;
            col_sum[j]  = SUM_MIN;
         end else begin
            col_sum[j] = wide_sum[63:0];
         end
      end
      if (last) begin
         for (j = 0; j < eprd_pkg::COLS; j++) col_sum[j] = '0;
      end
      return o;
   endfunction

   // Watch all three ports on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < eprd_pkg::COLS; k++) begin
            col_sum[k]    = '0;
            col_weight[k] = '0;
         end
         expected_dots.delete();
      end else begin
         if (csr_write_en) col_weight[csr_index] = csr_write_data;

         // compare before predicting so a stray beat never meets this row
         if (rsp_valid && !rsp_stall) begin
            if (expected_dots.size() == 0) begin
               report_mismatch($sformatf("response beat with no row pending, result %0d",
                                         rsp_row_result));
            end else begin
               want = expected_dots.pop_front();
               if (rsp_row_result !== want.row_result)
                  report_mismatch($sformatf("row_result got %0d want %0d",
                                            rsp_row_result, want.row_result));
               if (rsp_saturated !== want.saturated)
                  report_mismatch($sformatf("saturated got %b want %b",
                                            rsp_saturated, want.saturated));
            end
         end

         if (req_valid && !req_stall) begin
            beat_left  = '{req_left_0, req_left_1, req_left_2, req_left_3};
            beat_right = '{req_right_0, req_right_1, req_right_2, req_right_3};
            expected_dots.push_back(predict_dot(beat_left, beat_right,
                                                req_sample_value, req_last_row));
         end

         if (run_done && !drain_checked) begin
            drain_checked = 1'b1;
            if (expected_dots.size() != 0)
               report_mismatch($sformatf("%0d rows never answered", expected_dots.size()));
         end
      end
      expected_count <= expected_dots.size();
      fail_count     <= mismatches;
   end

endmodule

// ===== verif/tb_top.sv =====
// Top of the exclusive prefix rank dot testbench: clock, reset, row stimulus,
// response stall, weight writes and the verdict. Depends on eprd_pkg, the unit
// and rank_dot_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      eprd_pkg::val_type left [eprd_pkg::COLS];
      eprd_pkg::val_type right [eprd_pkg::COLS];
      eprd_pkg::val_type sample;
      logic              last;
   } row_type;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SOAK_ROWS     = 64;
   localparam int PHASE_ROWS    = 192;
   localparam int LATENCY_SLACK = 4;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   eprd_pkg::val_type               req_left_0 = '0;
   eprd_pkg::val_type               req_left_1 = '0;
   eprd_pkg::val_type               req_left_2 = '0;
   eprd_pkg::val_type               req_left_3 = '0;
   eprd_pkg::val_type               req_right_0 = '0;
   eprd_pkg::val_type               req_right_1 = '0;
   eprd_pkg::val_type               req_right_2 = '0;
   eprd_pkg::val_type               req_right_3 = '0;
   eprd_pkg::val_type               req_sample_value = '0;
   logic                            req_last_row = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   eprd_pkg::sum_type               rsp_row_result;
   logic                            rsp_saturated;
   logic                            csr_write_en = 1'b0;
   logic [eprd_pkg::CSR_IDX_W-1:0]  csr_index = eprd_pkg::CSR_WEIGHT_0;
   eprd_pkg::weight_type            csr_write_data = '0;
   logic                            run_done = 1'b0;
   int                              expected_count;
   int                              fail_count;
   int                              send_idle_pct = 0;
   int                              recv_stall_pct = 0;
   int                              quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   exclusive_prefix_rank_dot_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_left_0       (req_left_0),
      .req_left_1       (req_left_1),
      .req_left_2       (req_left_2),
      .req_left_3       (req_left_3),
      .req_right_0      (req_right_0),
      .req_right_1      (req_right_1),
      .req_right_2      (req_right_2),
      .req_right_3      (req_right_3),
      .req_sample_value (req_sample_value),
      .req_last_row     (req_last_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_result   (rsp_row_result),
      .rsp_saturated    (rsp_saturated),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   rank_dot_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_left_0       (req_left_0),
      .req_left_1       (req_left_1),
      .req_left_2       (req_left_2),
      .req_left_3       (req_left_3),
      .req_right_0      (req_right_0),
      .req_right_1      (req_right_1),
      .req_right_2      (req_right_2),
      .req_right_3      (req_right_3),
      .req_sample_value (req_sample_value),
      .req_last_row     (req_last_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_result   (rsp_row_result),
      .rsp_saturated    (rsp_saturated),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .run_done         (run_done),
      .expected_count   (expected_count),
      .fail_count       (fail_count)
   );

   // Random receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic eprd_pkg::val_type pick_val();
      case ($urandom_range(0, 9))
         0: return eprd_pkg::val_type'(-32768);
         1: return eprd_pkg::val_type'(32767);
         2: return '0;
         3: return eprd_pkg::val_type'(int'($urandom_range(0, 16)) - 8);
         default: return eprd_pkg::val_type'($urandom);
      endcase
   endfunction

   function automatic row_type random_row();
      row_type r;
      for (int j = 0; j < eprd_pkg::COLS; j++) begin
         r.left[j]  = pick_val();
         r.right[j] = pick_val();
      end
      r.sample = pick_val();
      r.last   = ($urandom_range(0, 15) == 0);
      return r;
   endfunction

   function automatic row_type uniform_row(input int u, input int v,
                                           input int x, input logic last);
      row_type r;
      for (int j = 0; j < eprd_pkg::COLS; j++) begin
         r.left[j]  = eprd_pkg::val_type'(u);
         r.right[j] = eprd_pkg::val_type'(v);
      end
      r.sample = eprd_pkg::val_type'(x);
      r.last   = last;
      return r;
   endfunction

   // Offer one row, idling first at the current rate, and hold until taken
   task automatic send_row(input row_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_left_0       <= r.left[0];
      req_left_1       <= r.left[1];
      req_left_2       <= r.left[2];
      req_left_3       <= r.left[3];
      req_right_0      <= r.right[0];
      req_right_1      <= r.right[1];
      req_right_2      <= r.right[2];
      req_right_3      <= r.right[3];
      req_sample_value <= r.sample;
      req_last_row     <= r.last;
      req_valid        <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop sending and wait until every pending response has drained
   task automatic drain_rows();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_count != 0) @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);
   endtask

   task automatic write_weights(input eprd_pkg::weight_type w [eprd_pkg::COLS]);
      logic [eprd_pkg::CSR_IDX_W-1:0] codes [eprd_pkg::COLS];
      codes = '{eprd_pkg::CSR_WEIGHT_0, eprd_pkg::CSR_WEIGHT_1,
                eprd_pkg::CSR_WEIGHT_2, eprd_pkg::CSR_WEIGHT_3};
      for (int j = 0; j < eprd_pkg::COLS; j++) begin
         csr_write_en   <= 1'b1;
         csr_index      <= codes[j];
         csr_write_data <= w[j];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   initial begin
      row_type               r;
      eprd_pkg::weight_type  w [eprd_pkg::COLS];
      int                    phase;
      int                    n;
      int                    idle_table [4];
      int                    stall_table [4];

      idle_table  = '{0, 60, 0, 6};
      stall_table = '{0, 0, 60, 6};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // weights still zero from reset: sums must stay zero
      send_row(uniform_row(-32768, 32767, -32768, 1'b0));
      send_row(uniform_row(32767, -32768, 32767, 1'b0));
      drain_rows();

      w = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      write_weights(w);

      // full-scale terms of both signs, then a row with zero sample
      send_row(uniform_row(-32768, -32768, -32768, 1'b0));
      send_row(uniform_row(32767, 32767, -32768, 1'b0));
      send_row(uniform_row(-32768, -32768, 32767, 1'b0));
      send_row(uniform_row(0, 32767, 0, 1'b0));
      // one column at a time, small values to exercise the floor
      r = uniform_row(0, 0, 1, 1'b0);
      r.left[0]  = eprd_pkg::val_type'(32767);
      r.right    = '{eprd_pkg::val_type'(-32768), eprd_pkg::val_type'(32767),
                     eprd_pkg::val_type'(1), eprd_pkg::val_type'(-1)};
      send_row(r);
      r = uniform_row(0, 1, 1, 1'b0);
      r.left[1]  = eprd_pkg::val_type'(-1);
      send_row(r);
      r = uniform_row(0, -1, 1, 1'b0);
      r.left[2]  = eprd_pkg::val_type'(1);
      send_row(r);
      r = uniform_row(0, 32767, 32767, 1'b0);
      r.left[3]  = eprd_pkg::val_type'(-32768);
      send_row(r);
      // last row still sees old sums, then the next rows start from zero
      send_row(uniform_row(-32768, 32767, -32768, 1'b1));
      send_row(uniform_row(1, 32767, 1, 1'b0));
      send_row(uniform_row(32767, -32768, -32768, 1'b1));
      send_row(uniform_row(-32768, 32767, 32767, 1'b1));
      send_row(uniform_row(123, -32768, -77, 1'b0));
      send_row(uniform_row(0, 0, 0, 1'b1));

      // accumulate full-scale terms against random right rows
      for (n = 0; n < SOAK_ROWS; n++) begin
         r = uniform_row(-32768, 0, -32768, 1'b0);
         for (int j = 0; j < eprd_pkg::COLS; j++) r.right[j] = pick_val();
         send_row(r);
      end
      send_row(uniform_row(0, 32767, 0, 1'b0));
      send_row(uniform_row(0, -32768, 0, 1'b0));
      send_row(uniform_row(32767, 32767, 32767, 1'b1));
      send_row(uniform_row(5, 32767, 3, 1'b0));
      drain_rows();

      // random rows under each idle and stall mix and weight setting
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: w = '{32'h0001_0000, 32'h0002_8000, 32'h0000_4000, 32'h0001_0000};
            1: w = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            2: w = '{$urandom, $urandom, $urandom, $urandom};
            default: w = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
         endcase
         write_weights(w);
         send_idle_pct  <= idle_table[phase];
         recv_stall_pct <= stall_table[phase];
         for (n = 0; n < PHASE_ROWS; n++) begin
            // hold off once until every response is back
            if (phase == 2 && n == PHASE_ROWS / 2) drain_rows();
            send_row(random_row());
         end
         drain_rows();
      end

      // tail: let any late beat show up, then close the books
      recv_stall_pct <= 0;
      repeat (8) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
